[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the port checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cmb_pkg.sv]
// ---------------------------------------------------------------------------
// Cat map scrambler package
// Beat types, register indexes and shared constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmb_pkg;

  localparam int SIDE_DEF = 5;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 3;

  localparam logic [CFG_IW-1:0] REG_MAP_P   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MAP_Q   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_INVERSE = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [4:0] pad_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [4:0] pad_out;
    logic       error_flag;
  } out_item_t;

  typedef struct packed {
    logic       init;
    logic       step;
    logic       inverse;
    logic [2:0] p;
    logic [2:0] q;
  } walk_ctl_t;

endpackage

[rtl/cmb_store.sv]
// ---------------------------------------------------------------------------
// Block store
// Single-port-write, single-port-read byte memory with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmb_store #(
  parameter int DEPTH = 25,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/cmb_walk.sv]
// ---------------------------------------------------------------------------
// Cat map walker
// Reduces P and Q, builds the step coefficients, then walks the source
// coordinates of each output cell in row-major output order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmb_walk import cmb_pkg::*; #(
  parameter  int BLOCK_SIDE = SIDE_DEF,
  localparam int AW = $clog2(BLOCK_SIDE * BLOCK_SIDE)
) (
  input  logic          clk,
  input  logic          rst,
  input  walk_ctl_t     ctl,
  output logic          ready,
  output logic [AW-1:0] addr
);

  localparam int CW = $clog2(BLOCK_SIDE);

  localparam logic [1:0] WK_IDLE  = 2'd0;
  localparam logic [1:0] WK_SETUP = 2'd1;
  localparam logic [1:0] WK_READY = 2'd2;

  function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (CW+1)'(BLOCK_SIDE)) s = s - (CW+1)'(BLOCK_SIDE);
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] neg_mod(input logic [CW-1:0] v);
    return (v == '0) ? '0 : CW'(BLOCK_SIDE) - v;
  endfunction

  function automatic logic [CW-1:0] coef_mod(input logic [2:0] v);
    logic [3:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 4; i++) begin
      if (int'(r) >= BLOCK_SIDE) r = r - 4'(BLOCK_SIDE);
    end
    return CW'(r);
  endfunction

  logic [1:0]    phase;
  logic          inverse;
  logic [CW-1:0] pm;
  logic [CW-1:0] qm;
  logic [CW-1:0] acc;
  logic [CW-1:0] cnt;
  logic [CW-1:0] col_dx;
  logic [CW-1:0] col_dy;
  logic [CW-1:0] row_dx;
  logic [CW-1:0] row_dy;
  logic [CW-1:0] base_x;
  logic [CW-1:0] base_y;
  logic [CW-1:0] cur_x;
  logic [CW-1:0] cur_y;
  logic [CW-1:0] col;
  logic [CW-1:0] base_x_next;
  logic [CW-1:0] base_y_next;

  assign base_x_next = add_mod(base_x, row_dx);
  assign base_y_next = add_mod(base_y, row_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= WK_IDLE;
    end else if (ctl.init) begin
      phase <= WK_SETUP;
    end else if (phase == WK_SETUP && cnt == '0) begin
      phase <= WK_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      inverse <= ctl.inverse;
      pm      <= coef_mod(ctl.p);
      qm      <= coef_mod(ctl.q);
      cnt     <= coef_mod(ctl.q);
      acc     <= CW'(1);
    end else if (phase == WK_SETUP) begin
      if (cnt != '0) begin
        acc <= add_mod(acc, pm);
        cnt <= cnt - CW'(1);
      end else begin
        if (inverse) begin
          col_dx <= CW'(1);
          col_dy <= qm;
          row_dx <= pm;
          row_dy <= acc;
        end else begin
          col_dx <= acc;
          col_dy <= neg_mod(qm);
          row_dx <= neg_mod(pm);
          row_dy <= CW'(1);
        end
        base_x <= '0;
        base_y <= '0;
        cur_x  <= '0;
        cur_y  <= '0;
        col    <= '0;
      end
    end else if (phase == WK_READY && ctl.step) begin
      if (col == CW'(BLOCK_SIDE - 1)) begin
        col    <= '0;
        base_x <= base_x_next;
        base_y <= base_y_next;
        cur_x  <= base_x_next;
        cur_y  <= base_y_next;
      end else begin
        col   <= col + CW'(1);
        cur_x <= add_mod(cur_x, col_dx);
        cur_y <= add_mod(cur_y, col_dy);
      end
    end
  end

  assign ready = (phase == WK_READY);
  assign addr  = AW'(int'(cur_y) * BLOCK_SIDE + int'(cur_x));

endmodule

[rtl/cat_map_block_scrambler_top.sv]
// ---------------------------------------------------------------------------
// Cat map block scrambler
// Loads a square byte block, permutes it by the cat map or its inverse and
// emits the result one byte per cycle.
// ---------------------------------------------------------------------------
// Load: one byte per cycle, busy stays low while a block is loading.
// After the last byte beat the walker builds its step coefficients, then the
// store is read and each result is registered. Throughput: one result per
// cycle; no new block loads until the last store read of the block.
// The receiver cannot stall; each result beat is held for one cycle only.
// Reset: the load counter clears, P = Q = 1, forward mode; store contents are kept.
`timescale 1ns / 1ps

module cat_map_block_scrambler_top import cmb_pkg::*; #(
  parameter int BLOCK_SIDE = SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_item_t          item,
  output logic              strobe,
  output out_item_t         result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int CELLS = BLOCK_SIDE * BLOCK_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]      state;
  logic [2:0]      map_p;
  logic [2:0]      map_q;
  logic            inverse_mode;
  logic [CNTW-1:0] load_count;
  logic            overflow_seen;
  logic [CNTW-1:0] job_total;
  logic [CNTW-1:0] job_count;
  logic [CNTW-1:0] job_pad;
  logic            job_err;
  logic            job_zero;
  logic [CNTW-1:0] emit_idx;
  logic            rd_valid;
  logic            rd_last;
  logic            rd_sub;
  logic [7:0]      rd_data;

  logic            accept;
  logic            fin;
  logic            wr_en;
  logic            room;
  logic [CNTW-1:0] cnt_fin;
  logic            err_fin;
  logic            emit_last;
  logic            walk_ready;
  logic [AW-1:0]   walk_addr;
  walk_ctl_t       walk_ctl;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_LOAD);
  assign accept    = start && (state == ST_LOAD);
  assign fin       = accept && item.last_byte;
  assign room      = (load_count < CNTW'(CELLS));
  assign wr_en     = accept && room;
  assign cnt_fin   = room ? load_count + CNTW'(1) : CNTW'(CELLS);
  assign err_fin   = overflow_seen || !room;
  assign emit_last = (emit_idx == job_total - CNTW'(1));

  assign walk_ctl.init    = fin;
  assign walk_ctl.step    = (state == ST_EMIT);
  assign walk_ctl.inverse = inverse_mode;
  assign walk_ctl.p       = map_p;
  assign walk_ctl.q       = map_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_p        <= 3'd1;
      map_q        <= 3'd1;
      inverse_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_P:   map_p        <= cfg_data;
        REG_MAP_Q:   map_q        <= cfg_data;
        REG_INVERSE: inverse_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (fin) begin
      load_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (room) begin
        load_count <= load_count + CNTW'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      if (!inverse_mode) begin
        job_total <= CNTW'(CELLS);
        job_count <= cnt_fin;
        job_pad   <= err_fin ? '0 : CNTW'(CELLS) - cnt_fin;
        job_err   <= err_fin;
        job_zero  <= 1'b0;
      end else if (err_fin || cnt_fin != CNTW'(CELLS)) begin
        job_total <= cnt_fin;
        job_count <= CNTW'(CELLS);
        job_pad   <= '0;
        job_err   <= 1'b1;
        job_zero  <= 1'b1;
      end else begin
        job_total <= (int'(item.pad_in) >= CELLS) ? '0
                   : CNTW'(CELLS) - CNTW'(item.pad_in);
        job_count <= CNTW'(CELLS);
        job_pad   <= '0;
        job_err   <= 1'b0;
        job_zero  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: begin
          if (fin) state <= ST_SETUP;
        end
        ST_SETUP: begin
          if (walk_ready) state <= (job_total == '0) ? ST_LOAD : ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_last) state <= ST_LOAD;
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      emit_idx <= '0;
    end else if (state == ST_EMIT) begin
      emit_idx <= emit_idx + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      rd_valid <= (state == ST_EMIT);
      strobe   <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd_last           <= emit_last;
    rd_sub            <= (CNTW'(walk_addr) >= job_count);
    result.out_byte   <= job_zero ? 8'd0 : (rd_sub ? 8'(job_pad) : rd_data);
    result.out_last   <= rd_last;
    result.pad_out    <= 5'(job_pad);
    result.error_flag <= job_err;
  end

  cmb_walk #(
    .BLOCK_SIDE(BLOCK_SIDE)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .ctl  (walk_ctl),
    .ready(walk_ready),
    .addr (walk_addr)
  );

  cmb_store #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(load_count[AW-1:0]),
    .wr_data(item.data_byte),
    .rd_en  (state == ST_EMIT),
    .rd_addr(walk_addr),
    .rd_data(rd_data)
  );

endmodule

[rtl/cmb_check.sv]
// ---------------------------------------------------------------------------
// Cat map scrambler port checker
// Watches the top-level ports for burst and handshake ordering slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmb_check import cmb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input in_item_t          item,
  input logic              strobe,
  input out_item_t         result
);

  logic last_beat;
  logic err_beat;

  assign last_beat = start && !busy && item.last_byte;
  assign err_beat  = strobe && result.error_flag;

  `CHK_IMPLY(a_beat_in_job, clk, rst, strobe, busy || $past(busy) || $past(busy, 2), "stray beat")
  `CHK_IMPLY(a_err_no_pad, clk, rst, err_beat, result.pad_out == 5'd0, "pad on error beat")
  `CHK_NEXT(a_burst_contig, clk, rst, strobe && !result.out_last, strobe, "gap in burst")
  `CHK_NEXT(a_last_busy, clk, rst, last_beat, busy, "no busy after last byte")

endmodule

bind cat_map_block_scrambler_top cmb_check u_check (.*);

[tb/cmb_checker.sv]
// ---------------------------------------------------------------------------
// Cat map scrambler checker
// Watches the item, result and register channels, keeps its own copy of the
// block store and the map settings, predicts every result beat of each block
// and compares the result beats in order, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmb_checker import cmb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          item,
  input  logic              strobe,
  input  out_item_t         result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                mismatch_count,
  output int                expected_left
);

  localparam int SIDE  = SIDE_DEF;
  localparam int CELLS = SIDE * SIDE;

  logic [2:0] coef_p;
  logic [2:0] coef_q;
  logic       unscramble;
  logic [7:0] cell_mem [CELLS];
  int         fill_count;
  logic       spilled;
  out_item_t  pending_beats [$];

  task automatic queue_beat(logic [7:0] b, logic l, logic [4:0] pad, logic e);
    out_item_t o;
    o.out_byte   = b;
    o.out_last   = l;
    o.pad_out    = pad;
    o.error_flag = e;
    pending_beats = {pending_beats, o};
  endtask

  task automatic absorb_byte(in_item_t it);
    logic [7:0] perm [CELLS];
    int p, q, count, pad, nx, ny, i, x, y;
    logic err;
    if (fill_count < CELLS) begin
      cell_mem[fill_count] = it.data_byte;
      fill_count++;
    end else begin
      spilled = 1'b1;
    end
    if (!it.last_byte) return;

    p = int'(coef_p) % SIDE;
    q = int'(coef_q) % SIDE;
    count = fill_count;
    err = spilled;
    fill_count = 0;
    spilled = 1'b0;

    if (!unscramble) begin
      pad = err ? 0 : CELLS - count;
      for (i = count; i < CELLS; i++) cell_mem[i] = 8'(pad);
      for (y = 0; y < SIDE; y++) begin
        for (x = 0; x < SIDE; x++) begin
          nx = (x + p * y) % SIDE;
          ny = (q * x + (p * q + 1) * y) % SIDE;
          perm[ny * SIDE + nx] = cell_mem[y * SIDE + x];
        end
      end
      for (i = 0; i < CELLS; i++) queue_beat(perm[i], i == CELLS - 1, 5'(pad), err);
    end else if (err || count != CELLS) begin
      for (i = 0; i < count; i++) queue_beat(8'h00, i == count - 1, 5'd0, 1'b1);
    end else begin
      for (y = 0; y < SIDE; y++) begin
        for (x = 0; x < SIDE; x++) begin
          nx = ((p * q + 1) * x + (SIDE - p) * y) % SIDE;
          ny = ((SIDE - q) * x + y) % SIDE;
          perm[ny * SIDE + nx] = cell_mem[y * SIDE + x];
        end
      end
      pad = (int'(it.pad_in) > CELLS) ? CELLS : int'(it.pad_in);
      for (i = 0; i < CELLS - pad; i++) queue_beat(perm[i], i == CELLS - pad - 1, 5'd0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      coef_p = 3'd1;
      coef_q = 3'd1;
      unscramble = 1'b0;
      fill_count = 0;
      spilled = 1'b0;
      mismatch_count = 0;
      pending_beats.delete();
    end else begin
      if (strobe) begin
        if (pending_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected beat byte=%02h last=%0b pad=%0d err=%0b", $realtime,
                     result.out_byte, result.out_last, result.pad_out, result.error_flag);
        end else begin
          want = pending_beats.pop_front();
          if (result.out_byte !== want.out_byte || result.out_last !== want.out_last ||
              result.pad_out !== want.pad_out || result.error_flag !== want.error_flag) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: byte/last/pad/err exp %02h/%0b/%0d/%0b got %02h/%0b/%0d/%0b",
                       $realtime, want.out_byte, want.out_last, want.pad_out,
                       want.error_flag, result.out_byte, result.out_last,
                       result.pad_out, result.error_flag);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAP_P:   coef_p = cfg_data;
          REG_MAP_Q:   coef_q = cfg_data;
          REG_INVERSE: unscramble = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) absorb_byte(item);
    end
    expected_left <= pending_beats.size();
  end

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Cat map scrambler testbench
// Loads byte blocks of lengths from 1 to 30 in forward and inverse mode under many
// map settings, with random gaps between beats; the checker predicts and
// compares every result beat, and this top gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import cmb_pkg::*;;

  localparam int ITEMS  = 450;
  localparam int LIMIT  = 2000;
  localparam int SETTLE = 80;

  typedef enum int {BLK_FULL, BLK_SHORT, BLK_SPILL} blk_kind_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  in_item_t          item;
  logic              strobe;
  out_item_t         result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                mismatch_count;
  int                expected_left;
  int                sent_items;
  bit                steady;

  cat_map_block_scrambler_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cmb_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item),
    .strobe         (strobe),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .expected_left  (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(logic [7:0] b, logic l, logic [4:0] pad);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item = '{data_byte: b, last_byte: l, pad_in: pad};
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_block(int len, logic [4:0] last_pad);
    int k;
    steady = ($urandom_range(0, 5) == 0);
    for (k = 0; k < len; k++)
      send_beat(8'($urandom_range(0, 255)), k == len - 1,
                (k == len - 1) ? last_pad : 5'($urandom_range(0, 31)));
    steady = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_mode(logic [2:0] p, logic [2:0] q, logic inv);
    write_reg(REG_MAP_P, p);
    write_reg(REG_MAP_Q, q);
    write_reg(REG_INVERSE, {2'b00, inv});
  endtask

  // hold until every beat is back and the block has gone quiet
  task automatic drain_block();
    start = 1'b0;
    while (expected_left != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int idle;
    idle = 0;
    while (idle < LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int phase, blk, nblk, len;
    logic inv;
    logic [4:0] last_pad;
    blk_kind_t kind;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MAP_P;
    cfg_data = '0;
    sent_items = 0;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: forward, single byte and two byte blocks
    send_beat(8'hFF, 1'b1, 5'd0);
    send_beat(8'h00, 1'b0, 5'd31);
    send_beat(8'hFF, 1'b1, 5'd31);
    drain_block();
    set_mode(3'd7, 3'd0, 1'b1);
    send_beat(8'h80, 1'b0, 5'd3);
    send_beat(8'h7F, 1'b0, 5'd16);
    send_beat(8'h01, 1'b1, 5'd25);
    send_beat(8'hFF, 1'b1, 5'd0);
    drain_block();
    set_mode(3'd0, 3'd7, 1'b0);
    send_beat(8'hAA, 1'b0, 5'd0);
    send_beat(8'h55, 1'b0, 5'd0);
    send_beat(8'hFF, 1'b0, 5'd0);
    send_beat(8'h00, 1'b1, 5'd31);
    drain_block();

    phase = 0;
    while (sent_items < ITEMS) begin
      inv = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      case (phase)
        0: set_mode(3'd0, 3'd0, 1'b0);
        1: set_mode(3'd7, 3'd7, 1'b1);
        2: set_mode(3'd5, 3'd4, 1'b0);
        3: set_mode(3'd4, 3'd5, 1'b1);
        default: set_mode(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), inv);
      endcase
      nblk = $urandom_range(1, 4);
      for (blk = 0; blk < nblk; blk++) begin
        len = $urandom_range(0, 99);
        if (inv) kind = (len < 70) ? BLK_FULL : (len < 88) ? BLK_SHORT : BLK_SPILL;
        else kind = (len < 30) ? BLK_FULL : (len < 90) ? BLK_SHORT : BLK_SPILL;
        last_pad = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 24))
                                                 : 5'($urandom_range(25, 31));
        if (phase == 0 && blk == 0) kind = BLK_SPILL;
        if (phase == 1 && blk == 0) begin
          kind = BLK_FULL;
          last_pad = 5'd31;
        end
        case (kind)
          BLK_FULL:  len = 25;
          BLK_SHORT: len = $urandom_range(1, 24);
          default:   len = $urandom_range(26, 30);
        endcase
        send_block(len, last_pad);
      end
      drain_block();
      phase++;
    end

    if (mismatch_count == 0 && expected_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
